// ----- sv/nrag_pkg.sv -----
// Shared types and constants of the NV12 rotate address generator.
package nrag_pkg;

    localparam int OFF_W      = 25;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE  = 2'd2;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [OFF_W-1:0] dest_offset;
        logic             is_chroma;
        logic             frame_last;
    } pixel_out_t;

    typedef struct packed {
        logic [OFF_W-1:0] luma_start;
        logic [OFF_W-1:0] luma_col_step;
        logic [OFF_W-1:0] luma_row_step;
        logic [OFF_W-1:0] chroma_start;
        logic [OFF_W-1:0] chroma_col_step;
        logic [OFF_W-1:0] chroma_row_step;
        logic             chroma_empty;
    } geom_t;

    typedef struct packed {
        logic [7:0]       pixel_byte;
        logic [OFF_W-1:0] elem_offset;
        logic             pair_byte;
        logic             is_chroma;
        logic             frame_last;
    } task_t;

endpackage

// ----- sv/nrag_config.sv -----
// Configuration registers and the derived rotation geometry.
module nrag_config #(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [nrag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nrag_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nrag_pkg::geom_t                   geom,
    output logic [DIM_W-1:0]                  luma_cols_m1,
    output logic [DIM_W-1:0]                  luma_rows_m1,
    output logic [DIM_W-1:0]                  chroma_cols_m1,
    output logic [DIM_W-1:0]                  chroma_rows_m1,
    output logic                              settled,
    output logic                              restart
);

    localparam int OFF_W     = nrag_pkg::OFF_W;
    localparam int RST_WIDTH = (640 > MAX_DIM) ? MAX_DIM : 640;
    localparam int RST_HEIGHT = (480 > MAX_DIM) ? MAX_DIM : 480;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               clockwise_reg;
    logic [1:0]         settle_reg;
    logic [DIM_W-1:0]   dim_clamped;
    logic [31:0]        cfg_wide;
    logic               wr_known;
    logic [DIM_W-1:0]   w2;
    logic [DIM_W-1:0]   h2;
    logic [2*DIM_W-1:0] prod_luma_full;
    logic [2*DIM_W-1:0] prod_chroma_full;
    logic [OFF_W-1:0]   prod_luma_reg;
    logic [OFF_W-1:0]   prod_chroma_reg;
    logic [OFF_W-1:0]   h_off;
    logic [OFF_W-1:0]   h2_off;
    logic [OFF_W-1:0]   h2_twice;
    logic [OFF_W-1:0]   chroma_cw_rel;
    logic [OFF_W-1:0]   chroma_ccw_rel;
    nrag_pkg::geom_t    geom_next;
    nrag_pkg::geom_t    geom_reg;
    logic [DIM_W-1:0]   luma_cols_m1_reg;
    logic [DIM_W-1:0]   luma_rows_m1_reg;
    logic [DIM_W-1:0]   chroma_cols_m1_reg;
    logic [DIM_W-1:0]   chroma_rows_m1_reg;

    assign cfg_wide = 32'(cfg_data);
    assign wr_known = cfg_valid && (cfg_index == nrag_pkg::REG_SRC_WIDTH
                      || cfg_index == nrag_pkg::REG_SRC_HEIGHT
                      || cfg_index == nrag_pkg::REG_CLOCKWISE);

    always_comb
    begin
        if (cfg_wide == 32'd0)
        begin
            dim_clamped = DIM_W'(1);
        end
        else if (cfg_wide > 32'(MAX_DIM))
        begin
            dim_clamped = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_clamped = DIM_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(RST_WIDTH);
            height_reg    <= DIM_W'(RST_HEIGHT);
            clockwise_reg <= 1'b1;
            settle_reg    <= 2'd2;
        end
        else
        begin
            if (wr_known)
            begin
                settle_reg <= 2'd2;
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (cfg_valid && cfg_index == nrag_pkg::REG_SRC_WIDTH)
            begin
                width_reg <= dim_clamped;
            end
            if (cfg_valid && cfg_index == nrag_pkg::REG_SRC_HEIGHT)
            begin
                height_reg <= dim_clamped;
            end
            if (cfg_valid && cfg_index == nrag_pkg::REG_CLOCKWISE)
            begin
                clockwise_reg <= cfg_data[0];
            end
        end
    end

    assign w2               = width_reg >> 1;
    assign h2               = height_reg >> 1;
    assign prod_luma_full   = (2*DIM_W)'(width_reg) * (2*DIM_W)'(height_reg);
    assign prod_chroma_full = (2*DIM_W)'(w2) * (2*DIM_W)'(h2);

    always_ff @(posedge clk)
    begin
        prod_luma_reg   <= OFF_W'(prod_luma_full);
        prod_chroma_reg <= OFF_W'(prod_chroma_full);
    end

    assign h_off          = OFF_W'(height_reg);
    assign h2_off         = OFF_W'(h2);
    assign h2_twice       = {h2_off[OFF_W-2:0], 1'b0};
    assign chroma_cw_rel  = h2_off - OFF_W'(1);
    assign chroma_ccw_rel = prod_chroma_reg - h2_off;

    always_comb
    begin
        geom_next.chroma_empty = (width_reg < DIM_W'(2)) || (height_reg < DIM_W'(2));
        if (clockwise_reg)
        begin
            geom_next.luma_start      = h_off - OFF_W'(1);
            geom_next.luma_col_step   = h_off;
            geom_next.luma_row_step   = '1;
            geom_next.chroma_start    = prod_luma_reg + {chroma_cw_rel[OFF_W-2:0], 1'b0};
            geom_next.chroma_col_step = h2_twice;
            geom_next.chroma_row_step = OFF_W'(0) - OFF_W'(2);
        end
        else
        begin
            geom_next.luma_start      = prod_luma_reg - h_off;
            geom_next.luma_col_step   = OFF_W'(0) - h_off;
            geom_next.luma_row_step   = OFF_W'(1);
            geom_next.chroma_start    = prod_luma_reg + {chroma_ccw_rel[OFF_W-2:0], 1'b0};
            geom_next.chroma_col_step = OFF_W'(0) - h2_twice;
            geom_next.chroma_row_step = OFF_W'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        geom_reg           <= geom_next;
        luma_cols_m1_reg   <= width_reg - DIM_W'(1);
        luma_rows_m1_reg   <= height_reg - DIM_W'(1);
        chroma_cols_m1_reg <= w2 - DIM_W'(1);
        chroma_rows_m1_reg <= h2 - DIM_W'(1);
    end

    assign geom           = geom_reg;
    assign luma_cols_m1   = luma_cols_m1_reg;
    assign luma_rows_m1   = luma_rows_m1_reg;
    assign chroma_cols_m1 = chroma_cols_m1_reg;
    assign chroma_rows_m1 = chroma_rows_m1_reg;
    assign settled        = (settle_reg == 2'd0);
    assign restart        = wr_known;

endmodule

// ----- sv/nrag_front.sv -----
// Front end: frame position counters and the destination offset of each element.
module nrag_front #(
    parameter int DIM_W = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  nrag_pkg::pixel_in_t  pix_data,
    input  nrag_pkg::geom_t      geom,
    input  logic [DIM_W-1:0]     luma_cols_m1,
    input  logic [DIM_W-1:0]     luma_rows_m1,
    input  logic [DIM_W-1:0]     chroma_cols_m1,
    input  logic [DIM_W-1:0]     chroma_rows_m1,
    input  logic                 settled,
    input  logic                 restart,
    input  logic                 queue_full,
    output logic                 push,
    output nrag_pkg::task_t      push_task
);

    localparam int OFF_W = nrag_pkg::OFF_W;

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             chroma_reg, chroma_next;
    logic             pair_reg, pair_next;
    logic [OFF_W-1:0] row_base_reg, row_base_next;
    logic [OFF_W-1:0] elem_reg, elem_next;
    logic             pend_reg;
    logic             fresh;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic             chroma;
    logic             pair;
    logic [OFF_W-1:0] row_base;
    logic [OFF_W-1:0] elem;
    logic [DIM_W-1:0] cols_m1;
    logic [DIM_W-1:0] rows_m1;
    logic             last;

    assign pix_ready = settled && !queue_full;
    assign push      = pix_valid && pix_ready;
    assign fresh     = pend_reg || pix_data.frame_start;
    assign col       = fresh ? '0 : col_reg;
    assign row       = fresh ? '0 : row_reg;
    assign chroma    = fresh ? 1'b0 : chroma_reg;
    assign pair      = fresh ? 1'b0 : pair_reg;
    assign row_base  = fresh ? geom.luma_start : row_base_reg;
    assign elem      = fresh ? geom.luma_start : elem_reg;
    assign cols_m1   = chroma ? chroma_cols_m1 : luma_cols_m1;
    assign rows_m1   = chroma ? chroma_rows_m1 : luma_rows_m1;

    always_comb
    begin
        col_next      = col;
        row_next      = row;
        chroma_next   = chroma;
        pair_next     = 1'b0;
        row_base_next = row_base;
        elem_next     = elem;
        last          = 1'b0;
        if (chroma && !pair)
        begin
            pair_next = 1'b1;
        end
        else if (col != cols_m1)
        begin
            col_next  = col + DIM_W'(1);
            elem_next = elem + (chroma ? geom.chroma_col_step : geom.luma_col_step);
        end
        else
        begin
            col_next = '0;
            if (row != rows_m1)
            begin
                row_next      = row + DIM_W'(1);
                row_base_next = row_base
                                + (chroma ? geom.chroma_row_step : geom.luma_row_step);
            end
            else
            begin
                row_next = '0;
                if (chroma || geom.chroma_empty)
                begin
                    last          = 1'b1;
                    chroma_next   = 1'b0;
                    row_base_next = geom.luma_start;
                end
                else
                begin
                    chroma_next   = 1'b1;
                    row_base_next = geom.chroma_start;
                end
            end
            elem_next = row_base_next;
        end
    end

    assign push_task.pixel_byte  = pix_data.pixel_byte;
    assign push_task.elem_offset = elem;
    assign push_task.pair_byte   = pair;
    assign push_task.is_chroma   = chroma;
    assign push_task.frame_last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            chroma_reg <= 1'b0;
            pair_reg   <= 1'b0;
            pend_reg   <= 1'b1;
        end
        else if (restart)
        begin
            pend_reg <= 1'b1;
        end
        else if (push)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            chroma_reg <= chroma_next;
            pair_reg   <= pair_next;
            pend_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            row_base_reg <= row_base_next;
            elem_reg     <= elem_next;
        end
    end

endmodule

// ----- sv/nrag_queue.sv -----
// Two-entry queue that decouples the front end from the output stage.
module nrag_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nrag_pkg::task_t push_task,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output nrag_pkg::task_t pop_task
);

    nrag_pkg::task_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_task  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

// ----- sv/nrag_back.sv -----
// Output stage: adds the pair byte to the element offset and holds the result.
module nrag_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 task_valid,
    input  nrag_pkg::task_t      task_in,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output nrag_pkg::pixel_out_t res_data
);

    logic                 valid_reg;
    nrag_pkg::pixel_out_t data_reg;
    nrag_pkg::pixel_out_t data_next;

    assign pop = task_valid && (!valid_reg || res_ready);

    always_comb
    begin
        data_next.out_byte    = task_in.pixel_byte;
        data_next.dest_offset = task_in.elem_offset
                                + nrag_pkg::OFF_W'(task_in.pair_byte);
        data_next.is_chroma   = task_in.is_chroma;
        data_next.frame_last  = task_in.frame_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// ----- sv/nv12_rotate_address_generator.sv -----
// NV12 rotate address generator: one byte in and one placed byte out per cycle unless stalled.
// The block accepts one byte of an NV12 frame per cycle while ready, luma plane first and then
// the interleaved CbCr pairs, and returns each byte with its offset in the frame rotated by 90
// degrees clockwise or counter-clockwise. An accepted byte passes through a two-entry queue
// and an output register, which absorb stalls downstream; the rate is one byte per cycle while
// the output is ready and the geometry is settled. The front end's counters advance the offset
// with one add per byte. After reset and after every write to a known register the geometry is
// recomputed through a registered multiplier and a geometry register, during which the input
// is not ready; the write also restarts the frame position at the first luma byte.
module nv12_rotate_address_generator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  nrag_pkg::pixel_in_t             pix_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output nrag_pkg::pixel_out_t            res_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nrag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrag_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    nrag_pkg::geom_t geom;
    logic [DIM_W-1:0] luma_cols_m1;
    logic [DIM_W-1:0] luma_rows_m1;
    logic [DIM_W-1:0] chroma_cols_m1;
    logic [DIM_W-1:0] chroma_rows_m1;
    logic             settled;
    logic             restart;
    logic             queue_full;
    logic             push;
    nrag_pkg::task_t  push_task;
    logic             pop;
    logic             task_valid;
    nrag_pkg::task_t  pop_task;

    assign cfg_ready = 1'b1;

    nrag_config #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_config (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .geom           (geom),
        .luma_cols_m1   (luma_cols_m1),
        .luma_rows_m1   (luma_rows_m1),
        .chroma_cols_m1 (chroma_cols_m1),
        .chroma_rows_m1 (chroma_rows_m1),
        .settled        (settled),
        .restart        (restart)
    );

    nrag_front #(
        .DIM_W (DIM_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .pix_data       (pix_data),
        .geom           (geom),
        .luma_cols_m1   (luma_cols_m1),
        .luma_rows_m1   (luma_rows_m1),
        .chroma_cols_m1 (chroma_cols_m1),
        .chroma_rows_m1 (chroma_rows_m1),
        .settled        (settled),
        .restart        (restart),
        .queue_full     (queue_full),
        .push           (push),
        .push_task      (push_task)
    );

    nrag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (task_valid),
        .pop_task  (pop_task)
    );

    nrag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_in    (pop_task),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

// ----- verif/nrag_placement_checker.sv -----
`timescale 1ns / 100ps
// Checker for the NV12 rotate address generator: predicts every placed byte and compares it.
module nrag_placement_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    input  logic                            pix_ready,
    input  nrag_pkg::pixel_in_t             pix_data,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  nrag_pkg::pixel_out_t            res_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [nrag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrag_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              errors
);

    localparam int          OFF_W        = nrag_pkg::OFF_W;
    localparam int          DATA_W       = nrag_pkg::CFG_DATA_W;
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    int unsigned          frame_w;
    int unsigned          frame_h;
    logic                 rot_cw;
    int unsigned          col;
    int unsigned          row;
    logic                 chroma_plane;
    logic                 second_byte;
    nrag_pkg::pixel_out_t placed_q[$];

    function automatic int unsigned clamp_dim(logic [DATA_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return 32'(v);
    endfunction

    function automatic logic [OFF_W-1:0] rotated_offset(int unsigned x, int unsigned y);
        longint unsigned w;
        longint unsigned h;
        longint unsigned base;
        longint unsigned esz;
        longint unsigned slot;
        w    = frame_w;
        h    = frame_h;
        base = 0;
        esz  = 1;
        if (chroma_plane)
        begin
            base = w * h;
            w    = w / 2;
            h    = h / 2;
            esz  = 2;
        end
        if (rot_cw)
        begin
            slot = x * h + (h - 1 - y);
        end
        else
        begin
            slot = (w - 1 - x) * h + y;
        end
        return OFF_W'(base + slot * esz + 64'(second_byte));
    endfunction

    task automatic restart_frame();
        col          = 0;
        row          = 0;
        chroma_plane = 1'b0;
        second_byte  = 1'b0;
    endtask

    task automatic place_byte(nrag_pkg::pixel_in_t item);
        nrag_pkg::pixel_out_t placed;
        int unsigned          pw;
        int unsigned          ph;
        logic                 no_chroma;
        no_chroma = (frame_w < 2) || (frame_h < 2);
        if (item.frame_start)
        begin
            restart_frame();
        end
        pw = chroma_plane ? frame_w / 2 : frame_w;
        ph = chroma_plane ? frame_h / 2 : frame_h;
        placed.out_byte    = item.pixel_byte;
        placed.dest_offset = rotated_offset(col, row);
        placed.is_chroma   = chroma_plane;
        placed.frame_last  = 1'b0;
        if (chroma_plane && !second_byte)
        begin
            second_byte = 1'b1;
        end
        else
        begin
            second_byte = 1'b0;
            col++;
            if (col >= pw)
            begin
                col = 0;
                row++;
                if (row >= ph)
                begin
                    row = 0;
                    if (chroma_plane || no_chroma)
                    begin
                        placed.frame_last = 1'b1;
                        chroma_plane      = 1'b0;
                    end
                    else
                    begin
                        chroma_plane = 1'b1;
                    end
                end
            end
        end
        placed_q.push_back(placed);
    endtask

    task automatic report(string field, logic [OFF_W-1:0] want, logic [OFF_W-1:0] got);
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endtask

    task automatic compare_placed(nrag_pkg::pixel_out_t got);
        nrag_pkg::pixel_out_t want;
        if (placed_q.size() == 0)
        begin
            errors++;
            $display("%0t: transaction expected none, got %p", $time, got);
            return;
        end
        want = placed_q.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            report("out_byte", OFF_W'(want.out_byte), OFF_W'(got.out_byte));
        end
        if (got.dest_offset !== want.dest_offset)
        begin
            report("dest_offset", want.dest_offset, got.dest_offset);
        end
        if (got.is_chroma !== want.is_chroma)
        begin
            report("is_chroma", OFF_W'(want.is_chroma), OFF_W'(got.is_chroma));
        end
        if (got.frame_last !== want.frame_last)
        begin
            report("frame_last", OFF_W'(want.frame_last), OFF_W'(got.frame_last));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_w = RESET_WIDTH;
            frame_h = RESET_HEIGHT;
            rot_cw  = 1'b1;
            errors  = 0;
            restart_frame();
            placed_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nrag_pkg::REG_SRC_WIDTH:
                    begin
                        frame_w = clamp_dim(cfg_data);
                        restart_frame();
                    end
                    nrag_pkg::REG_SRC_HEIGHT:
                    begin
                        frame_h = clamp_dim(cfg_data);
                        restart_frame();
                    end
                    nrag_pkg::REG_CLOCKWISE:
                    begin
                        rot_cw = cfg_data[0];
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (res_valid && res_ready)
            begin
                compare_placed(res_data);
            end
            if (pix_valid && pix_ready)
            begin
                place_byte(pix_data);
            end
            pending <= placed_q.size();
        end
    end

endmodule

// ----- verif/tb_nv12_rotate_address_generator.sv -----
`timescale 1ns / 100ps
// Testbench top for the NV12 rotate address generator: stimulus, output handshake and verdict.
module tb_nv12_rotate_address_generator;

    localparam int DATA_W      = nrag_pkg::CFG_DATA_W;
    localparam int ITEM_TARGET = 1800;
    localparam int CALM_TAIL   = 200;
    localparam int LONG_HOLD   = 60;
    localparam logic [nrag_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            pix_valid;
    logic                            pix_ready;
    nrag_pkg::pixel_in_t             pix_data;
    logic                            res_valid;
    logic                            res_ready;
    nrag_pkg::pixel_out_t            res_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [nrag_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nrag_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              pending;
    int                              errors;

    int bytes_sent;
    int idle_pct;
    bit calm;
    bit long_hold_due;

    nv12_rotate_address_generator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix_data(pix_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    nrag_placement_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix_data(pix_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(pending),
        .errors(errors)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("tb_nv12_rotate_address_generator failed");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic fs);
        pix_data  <= nrag_pkg::pixel_in_t'{pixel_byte: b, frame_start: fs};
        pix_valid <= 1'b1;
        do @(posedge clk); while (!pix_ready);
        bytes_sent++;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [nrag_pkg::CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [DATA_W-1:0] w, logic [DATA_W-1:0] h, logic cw);
        logic [11:0] spare_bits;
        spare_bits = 12'($urandom);
        settle();
        write_reg(nrag_pkg::REG_SRC_WIDTH, w);
        write_reg(nrag_pkg::REG_SRC_HEIGHT, h);
        write_reg(nrag_pkg::REG_CLOCKWISE, {spare_bits, cw});
    endtask

    function automatic int frame_bytes(int w, int h);
        return w * h + (w / 2) * (h / 2) * 2;
    endfunction

    initial
    begin : sink
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int          w;
        int          h;
        bit          big;
        int          phase;
        int          len;
        int          frames;
        bit          resync;
        logic [11:0] spare_bits;
        rst_n         = 1'b0;
        pix_valid     = 1'b0;
        pix_data      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        bytes_sent    = 0;
        idle_pct      = 0;
        calm          = 1'b0;
        long_hold_due = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        settle();
        write_reg(REG_SPARE, 13'h1FFF);
        send_byte(8'($urandom), 1'b0);
        configure(13'd0, 13'h1FFF, 1'b0);
        repeat (2) send_byte(8'($urandom), 1'b0);
        configure(13'd4096, 13'd4096, 1'b1);
        repeat (2) send_byte(8'($urandom), 1'b0);
        configure(13'd4096, 13'd4096, 1'b0);
        repeat (2) send_byte(8'($urandom), 1'b0);
        configure(13'd1, 13'd1, 1'b1);
        repeat (3) send_byte(8'($urandom), 1'b0);
        configure(13'd3, 13'd2, 1'b1);
        send_byte(8'($urandom), 1'b1);
        repeat (9) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);

        w     = 3;
        h     = 2;
        big   = 1'b0;
        phase = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            calm     = bytes_sent >= ITEM_TARGET - CALM_TAIL;
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 20 : 50);
            if ($urandom_range(0, 3) == 0)
            begin
                spare_bits = 12'($urandom);
                settle();
                write_reg(nrag_pkg::REG_CLOCKWISE, {spare_bits, 1'($urandom_range(0, 1))});
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        w   = $urandom_range(1000, 4096);
                        h   = $urandom_range(1000, 4096);
                        big = 1'b1;
                    end
                    1:
                    begin
                        w   = $urandom_range(1, 2);
                        h   = $urandom_range(1, 3);
                        big = 1'b0;
                    end
                    default:
                    begin
                        w   = $urandom_range(1, 10);
                        h   = $urandom_range(1, 8);
                        big = 1'b0;
                    end
                endcase
                configure(DATA_W'(w), DATA_W'(h), 1'($urandom_range(0, 1)));
            end
            if (phase == 4)
            begin
                idle_pct      = 0;
                long_hold_due = 1'b1;
            end
            if (big || phase == 4)
            begin
                repeat (30) send_byte(8'($urandom), $urandom_range(0, 19) == 0);
            end
            else
            begin
                frames = $urandom_range(1, 3);
                resync = 1'b1;
                repeat (frames)
                begin
                    len = frame_bytes(w, h);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        len = $urandom_range(1, len);
                    end
                    for (int i = 0; i < len; i++)
                    begin
                        send_byte(8'($urandom), i == 0 && (resync || $urandom_range(0, 1)));
                    end
                    resync = len != frame_bytes(w, h);
                end
            end
            phase++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_nv12_rotate_address_generator passed");
        end
        else
        begin
            $display("tb_nv12_rotate_address_generator failed");
        end
        $finish;
    end

endmodule
